FILE: design/rme_pkg.sv
// ============================================================================
// rme_pkg
// Shared constants and controller/datapath interface types for the modular
// exponentiation block.
// ============================================================================
package rme_pkg;

   localparam int WORD_BITS_DEFAULT = 31;

   // Configuration register indexes.
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MODULUS  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_EXPONENT = 2'd1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_msg;     // capture message and exponent
      logic reduce_step;  // one remainder bit of message mod modulus
      logic reduce_last;  // last remainder bit: set base and accumulator
      logic mul_step;     // one interleaved modular multiply bit
      logic mul_last;     // last multiply bit: write product to accumulator
      logic next_base;    // with mul_last: next multiplier operand is the base
      logic exp_shift;    // move to the next exponent bit
      logic out_load;     // load the result register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic exp_msb;      // current exponent bit
   } status_type;

endpackage

FILE: design/rme_datapath.sv
// ============================================================================
// rme_datapath
// Configuration registers, remainder and interleaved modular multiply
// datapath, and the result register.
// ============================================================================
module rme_datapath
   import rme_pkg::*;
#(
   parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [WORD_BITS-1:0]      csr_data,
   input  logic [WORD_BITS-1:0]      req_message,
   input  cmd_type                   cmd,
   output status_type                status,
   output logic [WORD_BITS-1:0]      rsp_power_result
);

   localparam int SUM_BITS = WORD_BITS + 2;

   logic [WORD_BITS-1:0] modulus_ff;
   logic [WORD_BITS-1:0] exponent_ff;
   logic [WORD_BITS-1:0] exp_sh_ff;
   logic [WORD_BITS-1:0] base_ff;
   logic [WORD_BITS-1:0] acc_ff;
   logic [WORD_BITS-1:0] prod_ff;
   logic [WORD_BITS-1:0] oper_ff;
   logic [WORD_BITS-1:0] out_ff;

   logic [WORD_BITS:0]   rem_raw;
   logic [WORD_BITS-1:0] rem_in;
   logic [SUM_BITS-1:0]  mod1;
   logic [SUM_BITS-1:0]  mod2;
   logic [SUM_BITS-1:0]  sum;
   logic [SUM_BITS-1:0]  sum_red;
   logic [WORD_BITS-1:0] mul_in;
   logic [WORD_BITS-1:0] acc_init;

   // Remainder step: shift in the next message bit and subtract once.
   always_comb begin
      rem_raw = {prod_ff, oper_ff[WORD_BITS-1]};
      if (rem_raw >= {1'b0, modulus_ff}) begin
         rem_in = WORD_BITS'(rem_raw - {1'b0, modulus_ff});
      end else begin
         rem_in = rem_raw[WORD_BITS-1:0];
      end
   end

   // Multiply step: 2*prod + bit*acc is below three times the modulus, so
   // subtracting zero, one or two moduli brings it back into range.
   always_comb begin
      mod1 = {2'b00, modulus_ff};
      mod2 = {1'b0, modulus_ff, 1'b0};
      sum  = {1'b0, prod_ff, 1'b0}
             + (oper_ff[WORD_BITS-1] ? {2'b00, acc_ff} : '0);
      if (sum >= mod2) begin
         sum_red = sum - mod2;
      end else if (sum >= mod1) begin
         sum_red = sum - mod1;
      end else begin
         sum_red = sum;
      end
      mul_in = sum_red[WORD_BITS-1:0];
   end

   // One modulo the modulus: zero for a modulus of one.
   assign acc_init = (modulus_ff == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff  <= WORD_BITS'(2);
         exponent_ff <= WORD_BITS'(1);
      end else if (csr_valid) begin
         if (csr_index == CSR_MODULUS) begin
            modulus_ff <= csr_data;
         end
         if (csr_index == CSR_EXPONENT) begin
            exponent_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_msg) begin
         oper_ff   <= req_message;
         prod_ff   <= '0;
         exp_sh_ff <= exponent_ff;
      end
      if (cmd.reduce_step) begin
         if (cmd.reduce_last) begin
            base_ff <= rem_in;
            acc_ff  <= acc_init;
            oper_ff <= acc_init;
            prod_ff <= '0;
         end else begin
            prod_ff <= rem_in;
            oper_ff <= {oper_ff[WORD_BITS-2:0], 1'b0};
         end
      end
      if (cmd.mul_step) begin
         if (cmd.mul_last) begin
            acc_ff  <= mul_in;
            prod_ff <= '0;
            oper_ff <= cmd.next_base ? base_ff : mul_in;
         end else begin
            prod_ff <= mul_in;
            oper_ff <= {oper_ff[WORD_BITS-2:0], 1'b0};
         end
      end
      if (cmd.exp_shift) begin
         exp_sh_ff <= {exp_sh_ff[WORD_BITS-2:0], 1'b0};
      end
      if (cmd.out_load) begin
         out_ff <= (modulus_ff == '0) ? '0 : acc_ff;
      end
   end

   assign status.exp_msb   = exp_sh_ff[WORD_BITS-1];
   assign rsp_power_result = out_ff;

endmodule

FILE: design/rme_controller.sv
// ============================================================================
// rme_controller
// Sequencer for message reduction and square-and-multiply over the
// exponent bits, plus the request and response handshakes.
// ============================================================================
module rme_controller
   import rme_pkg::*;
#(
   parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam int CNT_BITS = $clog2(WORD_BITS);
   localparam logic [CNT_BITS-1:0] LAST = CNT_BITS'(WORD_BITS - 1);

   typedef enum logic [2:0] {
      IDLE,
      REDUCE,
      SQUARE,
      MULT,
      DONE
   } state_type;

   state_type           state_ff;
   state_type           state_in;
   logic [CNT_BITS-1:0] cnt_ff;
   logic [CNT_BITS-1:0] cnt_in;
   logic [CNT_BITS-1:0] bit_cnt_ff;
   logic [CNT_BITS-1:0] bit_cnt_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                step_last;
   logic                bit_last;

   assign step_last = (cnt_ff == LAST);
   assign bit_last  = (bit_cnt_ff == LAST);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      bit_cnt_in   = bit_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd.load_msg = 1'b1;
               cnt_in       = '0;
               bit_cnt_in   = '0;
               state_in     = REDUCE;
            end
         end
         REDUCE: begin
            cmd.reduce_step = 1'b1;
            cmd.reduce_last = step_last;
            cnt_in          = step_last ? '0 : cnt_ff + 1'b1;
            if (step_last) begin
               state_in = SQUARE;
            end
         end
         SQUARE: begin
            cmd.mul_step = 1'b1;
            cmd.mul_last = step_last;
            cnt_in       = step_last ? '0 : cnt_ff + 1'b1;
            if (step_last) begin
               if (status.exp_msb) begin
                  cmd.next_base = 1'b1;
                  state_in      = MULT;
               end else begin
                  cmd.exp_shift = 1'b1;
                  bit_cnt_in    = bit_cnt_ff + 1'b1;
                  state_in      = bit_last ? DONE : SQUARE;
               end
            end
         end
         MULT: begin
            cmd.mul_step = 1'b1;
            cmd.mul_last = step_last;
            cnt_in       = step_last ? '0 : cnt_ff + 1'b1;
            if (step_last) begin
               cmd.exp_shift = 1'b1;
               bit_cnt_in    = bit_cnt_ff + 1'b1;
               state_in      = bit_last ? DONE : SQUARE;
            end
         end
         DONE: begin
            // Wait until the result register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         cnt_ff       <= '0;
         bit_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         bit_cnt_ff   <= bit_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: design/rsa_modular_exponentiation.sv
// The block takes a new request only while idle, so one message is in work at a
// time; the bit-serial modular multiply (one product bit per cycle) and the
// bit-serial message remainder set its pace.
// A finished result waits in the output register while the next item runs.
// Reset: synchronous; modulus 2, exponent 1, idle, no response pending.
// ============================================================================
// rsa_modular_exponentiation
// Raises each message word to the configured exponent modulo the configured
// modulus by left-to-right square-and-multiply.
// ============================================================================
module rsa_modular_exponentiation
   import rme_pkg::*;
#(
   parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [WORD_BITS-1:0]      req_message,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [WORD_BITS-1:0]      rsp_power_result,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [WORD_BITS-1:0]      csr_data
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   rme_controller #(
      .WORD_BITS (WORD_BITS)
   ) u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rme_datapath #(
      .WORD_BITS (WORD_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_message      (req_message),
      .cmd              (cmd),
      .status           (status),
      .rsp_power_result (rsp_power_result)
   );

`ifndef SYNTHESIS
   // A request transfer always starts a computation, so the block is busy next.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while a computation was starting");

   // The result register is never overwritten while a response is pending.
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid || rsp_ready))
      else $error("result overwritten before its transfer");

   // The message is captured only on a request transfer.
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_msg |-> (req_valid && req_ready))
      else $error("message captured without a request transfer");
`endif

endmodule

FILE: tb/tb_top.sv
// ============================================================================
// tb_top
// Self-checking bench for the modular exponentiation block. Each message
// transfer is paired with an exact power computed here with 64-bit products
// and the live register settings. Every result transfer is compared in order
// against these expectations. Directed cases cover the field extremes and the
// degenerate moduli. Randomized keys and messages then run under three idle
// profiles, followed by output back-pressure and a sender pause.
// ============================================================================
module tb_top
   import rme_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WORD_BITS = WORD_BITS_DEFAULT;
   localparam int HALF_PERIOD = 10;
   localparam int STALL_LIMIT = 30000;
   localparam int HOLD_OFF_CYCLES = 6000;
   localparam int TAIL_CYCLES = 2000;

   // Indexes with no register behind them; writes there must be ignored.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_HI = 2'd3;

   typedef logic [WORD_BITS-1:0] word_type;

   localparam word_type WORD_MAX = {WORD_BITS{1'b1}};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   word_type req_message = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   word_type rsp_power_result;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_MODULUS;
   word_type csr_data = '0;

   // Register copies used by the power predictor.
   word_type modulus_setting = word_type'(2);
   word_type exponent_setting = word_type'(1);

   word_type power_expected[$];
   int error_count = 0;
   int idle_cycles = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int ready_hold_cycles = 0;

   rsa_modular_exponentiation #(
      .WORD_BITS(WORD_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_message(req_message),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_power_result(rsp_power_result),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // message ** exponent mod modulus by left-to-right square-and-multiply.
   // Operands stay below 2**31, so every product fits in 64 bits.
   function automatic word_type modular_power(word_type message);
      longint unsigned base;
      longint unsigned acc;
      longint unsigned m;
      m = longint'(modulus_setting);
      if (m == 0)
         return '0;
      base = longint'(message) % m;
      acc = 1 % m;
      for (int idx = WORD_BITS - 1; idx >= 0; idx--) begin
         acc = (acc * acc) % m;
         if (exponent_setting[idx])
            acc = (acc * base) % m;
      end
      return word_type'(acc);
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t mismatch: %s", $realtime, what);
      error_count++;
   endtask

   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] index, input word_type value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_MODULUS:  modulus_setting = value;
         CSR_EXPONENT: exponent_setting = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic load_key(input word_type modulus, input word_type exponent);
      write_register(CSR_MODULUS, modulus);
      write_register(CSR_EXPONENT, exponent);
   endtask

   // Leaves req_valid high after the transfer; a drain lowers it, and so may the next call.
   task automatic send_message(input word_type message);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_message <= message;
      do @(posedge clock); while (!req_ready);
      power_expected = {power_expected, modular_power(message)};
   endtask

   task automatic wait_drained;
      @(negedge clock);
      req_valid <= 1'b0;
      while (power_expected.size() != 0)
         @(posedge clock);
   endtask

   function automatic word_type pick_message(word_type modulus);
      case ($urandom_range(5))
         0: return (modulus == 0) ? '0 : word_type'($urandom % modulus);
         1: return (modulus == 0) ? '0 : modulus - 1'b1;
         2: return word_type'($urandom_range(1));
         default: return word_type'($urandom);
      endcase
   endfunction

   // ---------------------------------------------------------------- tests

   task automatic test_reset_defaults;
      send_message('0);
      send_message(word_type'(1));
      send_message(WORD_MAX);
      wait_drained;
   endtask

   task automatic test_field_extremes;
      load_key(WORD_MAX, WORD_MAX);
      send_message('0);
      send_message(word_type'(1));
      send_message(WORD_MAX);             // equal to the modulus, reduces to zero
      send_message(WORD_MAX - 1'b1);
      wait_drained;
   endtask

   task automatic test_zero_exponent;
      load_key(word_type'(1000003), '0);
      send_message('0);
      send_message(WORD_MAX);
      wait_drained;
   endtask

   task automatic test_degenerate_modulus;
      load_key(word_type'(1), word_type'(65537));
      send_message(word_type'(7));
      send_message(WORD_MAX);
      wait_drained;
      load_key('0, word_type'(3));
      send_message(word_type'(9));
      send_message(WORD_MAX);
      wait_drained;
   endtask

   task automatic test_spare_registers;
      load_key(word_type'(1000003), word_type'(5));
      write_register(CSR_SPARE_LO, WORD_MAX);
      write_register(CSR_SPARE_HI, '0);
      send_message(word_type'(123456));
      wait_drained;
   endtask

   task automatic test_textbook_key;
      // n = 61 * 53, e = 17, d = 2753: encrypt 65 and 3232, then decrypt the cipher word of 65.
      load_key(word_type'(3233), word_type'(17));
      send_message(word_type'(65));
      send_message(word_type'(3232));
      wait_drained;
      write_register(CSR_EXPONENT, word_type'(2753));
      send_message(word_type'(2790));
      wait_drained;
   endtask

   task automatic test_random_keys(input int send_pct, input int recv_pct,
                                   input int key_sets, input int items_per_key);
      word_type modulus;
      word_type exponent;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int k = 0; k < key_sets; k++) begin
         case ($urandom_range(3))
            0: modulus = word_type'($urandom) | (word_type'(1) << (WORD_BITS - 1));
            1: modulus = word_type'($urandom_range(2, 1000));
            2: modulus = WORD_MAX;
            default: modulus = word_type'($urandom_range(2, 32'h7fff_ffff));
         endcase
         // Sparse exponents keep most items near the short end of the latency.
         case ($urandom_range(9))
            0, 1, 2, 3: exponent = word_type'($urandom & $urandom & $urandom);
            4, 5: exponent = word_type'($urandom);
            6, 7: exponent = word_type'($urandom_range(0, 70000));
            8: exponent = '0;
            default: exponent = WORD_MAX;
         endcase
         load_key(modulus, exponent);
         for (int i = 0; i < items_per_key; i++)
            send_message(pick_message(modulus));
         wait_drained;
      end
   endtask

   task automatic test_output_backpressure;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      load_key(word_type'(3233), word_type'(17));
      // The receiver holds off while messages keep coming, so the block fills
      // and has to stall the request side.
      ready_hold_cycles = HOLD_OFF_CYCLES;
      for (int i = 0; i < 6; i++)
         send_message(pick_message(word_type'(3233)));
      wait_drained;
   endtask

   task automatic test_sender_pause;
      send_idle_pct = 10;
      recv_idle_pct = 10;
      load_key(word_type'(2147483629), word_type'(65537));
      for (int i = 0; i < 3; i++)
         send_message(word_type'($urandom));
      wait_drained;
      for (int i = 0; i < 3; i++)
         send_message(word_type'($urandom));
      wait_drained;
   endtask

   // ------------------------------------------------------------ processes

   always @(negedge clock) begin
      if (ready_hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         ready_hold_cycles--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : check_results
      word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (power_expected.size() == 0) begin
            report_mismatch($sformatf("result %0d with no message outstanding",
                                      rsp_power_result));
         end else begin
            want = power_expected.pop_front();
            if (rsp_power_result !== want)
               report_mismatch($sformatf("power_result %0d, expected %0d",
                                         rsp_power_result, want));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t no transfer for %0d cycles", $realtime, STALL_LIMIT);
         $display("[rsa_modular_exponentiation] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 20;
      recv_idle_pct = 59;
      test_reset_defaults;
      test_field_extremes;
      test_zero_exponent;
      test_degenerate_modulus;
      test_spare_registers;
      test_textbook_key;

      test_random_keys(20, 59, 7, 27);
      test_random_keys(59, 20, 7, 27);
      test_random_keys(0, 0, 7, 27);

      test_output_backpressure;
      test_sender_pause;

      wait_drained;
      repeat (TAIL_CYCLES) @(posedge clock);
      if (power_expected.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", power_expected.size()));
      if (error_count == 0)
         $display("[rsa_modular_exponentiation] OK");
      else
         $display("[rsa_modular_exponentiation] ERROR");
      $finish;
   end

endmodule
